@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psa: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define PSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psa: next-cycle property failed");

// Next-cycle implication that is also checked during reset.
`define PSA_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("psa: reset property failed");

`endif

@@ rtl/psa_pkg.sv @@
package psa_pkg;

    // Widths of the stream fields and of the configuration port.
    localparam int FIELD_W        = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int DATA_WIDTH_DEF = 32;

    // Digit-serial multiplier geometry: a signed multiplicand of up to 48 bits
    // times a 32-bit multiplier, retired four bits per cycle.
    localparam int DIGIT_W = 4;
    localparam int MULT_W  = 32;
    localparam int MCAND_W = 48;

    // 1.0 in unsigned Q15.16.
    localparam logic [30:0] ONE_Q16 = 31'd65536;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TARGET     = 3'd0,
        CFG_BASE       = 3'd1,
        CFG_STEP       = 3'd2,
        CFG_INV_STEP   = 3'd3,
        CFG_INV_INTEG  = 3'd4,
        CFG_DERIV_TIME = 3'd5,
        CFG_SCALE      = 3'd6
    } t_cfg_addr;

    // Clamp a signed value to the range of a w-bit signed number.
    function automatic logic signed [63:0] sat_signed(input logic signed [63:0] v,
                                                      input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end else begin
            return v;
        end
    endfunction

endpackage

@@ rtl/pid_setpoint_adjuster.sv @@
// Each accepted input transaction runs three multiply passes (start, eight 4-bit
// digit steps, done), a sum state and an output state before its result is valid;
// no new input is taken until the sequencer is back in idle. A result held by
// m_axis_tready stalls the next transaction in its output state.
// Reset (synchronous, active low): step, reciprocal, time and scale registers
// go to 1.0, target and base to 0, integral and previous error are cleared.
module pid_setpoint_adjuster #(
    parameter int DATA_WIDTH = psa_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: measured_value [31:0]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [psa_pkg::FIELD_W-1:0]         s_axis_tdata,
    // tdata: new_setting [31:0], control_value [63:32]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*psa_pkg::FIELD_W-1:0]       m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [psa_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [psa_pkg::FIELD_W-1:0]         i_cfg_wdata
);

    localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int PROD_W = psa_pkg::MCAND_W + psa_pkg::MULT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START1,
        S_MUL1,
        S_START2,
        S_MUL2,
        S_SUM,
        S_START3,
        S_MUL3,
        S_SET
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // Configuration registers.
    logic signed [31:0] r_target;
    logic signed [31:0] r_base;
    logic [30:0]        r_step;
    logic [30:0]        r_inv_step;
    logic [30:0]        r_inv_integ;
    logic [30:0]        r_deriv_time;
    logic [31:0]        r_scale;

    // Controller state.
    logic signed [47:0] r_integral;
    logic signed [31:0] r_prev;

    // Per-transaction working registers.
    logic signed [31:0] r_err;
    logic signed [31:0] r_deriv;
    logic signed [62:0] r_ti;
    logic signed [46:0] r_td;
    logic signed [31:0] r_control;
    logic [2*psa_pkg::FIELD_W-1:0] r_out_data;

    logic w_in_accept;
    logic w_out_free;
    logic w_both_done;

    logic signed [31:0] w_meas;
    logic signed [32:0] w_err_full;
    logic signed [32:0] w_sum;
    logic signed [32:0] w_diff;
    logic signed [47:0] w_inc;
    logic signed [48:0] w_integ_full;
    logic signed [63:0] w_deriv_wide;
    logic signed [63:0] w_ctl_full;
    logic signed [47:0] w_scaled;
    logic signed [63:0] w_set_full;

    logic signed [31:0] n_err;
    logic signed [47:0] n_integral;
    logic signed [31:0] n_deriv;
    logic signed [31:0] n_control;
    logic signed [31:0] n_setting;

    logic                                 u0_start;
    logic signed [psa_pkg::MCAND_W-1:0]   u0_mcand;
    logic [psa_pkg::MULT_W-1:0]           u0_mult;
    logic                                 u0_done;
    logic signed [PROD_W-1:0]             w_p0;
    logic                                 u1_start;
    logic signed [psa_pkg::MCAND_W-1:0]   u1_mcand;
    logic [psa_pkg::MULT_W-1:0]           u1_mult;
    logic                                 u1_done;
    logic signed [PROD_W-1:0]             w_p1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_both_done   = u0_done && u1_done;

    // Error, integral, derivative, control and setting arithmetic.
    always_comb begin
        w_meas       = $signed(s_axis_tdata);
        w_err_full   = 33'(r_target) - 33'(w_meas);
        n_err        = 32'(psa_pkg::sat_signed(64'(w_err_full), SAT_W));

        w_sum        = 33'(r_prev) + 33'(r_err);
        w_diff       = 33'(r_err) - 33'(r_prev);

        // Trapezoid step: the product is shifted by 17 to fold in the halving.
        w_inc        = $signed(w_p0[64:17]);
        w_integ_full = 49'(r_integral) + 49'(w_inc);
        n_integral   = 48'(psa_pkg::sat_signed(64'(w_integ_full), 48));

        w_deriv_wide = $signed(w_p1[79:16]);
        n_deriv      = 32'(psa_pkg::sat_signed(w_deriv_wide, 32));

        w_ctl_full   = 64'(r_err) + 64'(r_ti) + 64'(r_td);
        n_control    = 32'(psa_pkg::sat_signed(w_ctl_full, SAT_W));

        w_scaled     = $signed(w_p0[63:16]);
        w_set_full   = 64'(r_base) + 64'(w_scaled);
        n_setting    = 32'(psa_pkg::sat_signed(w_set_full, SAT_W));
    end

    // Operand selection for the two multipliers in each pass.
    always_comb begin
        u0_start = (r_state == S_START1) || (r_state == S_START2) || (r_state == S_START3);
        u1_start = (r_state == S_START1) || (r_state == S_START2);
        unique case (r_state)
            S_START2: begin
                u0_mcand = r_integral;
                u0_mult  = {1'b0, r_inv_integ};
                u1_mcand = 48'(r_deriv);
                u1_mult  = {1'b0, r_deriv_time};
            end
            S_START3: begin
                u0_mcand = 48'(r_control);
                u0_mult  = r_scale;
                u1_mcand = 48'(w_diff);
                u1_mult  = {1'b0, r_inv_step};
            end
            default: begin
                u0_mcand = 48'(w_sum);
                u0_mult  = {1'b0, r_step};
                u1_mcand = 48'(w_diff);
                u1_mult  = {1'b0, r_inv_step};
            end
        endcase
    end

    psa_digit_mult #(
        .MCAND_W (psa_pkg::MCAND_W),
        .MULT_W  (psa_pkg::MULT_W),
        .DIGIT_W (psa_pkg::DIGIT_W)
    ) u_mult0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (u0_start),
        .i_mcand   (u0_mcand),
        .i_mult    (u0_mult),
        .o_done    (u0_done),
        .o_product (w_p0)
    );

    psa_digit_mult #(
        .MCAND_W (psa_pkg::MCAND_W),
        .MULT_W  (psa_pkg::MULT_W),
        .DIGIT_W (psa_pkg::DIGIT_W)
    ) u_mult1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (u1_start),
        .i_mcand   (u1_mcand),
        .i_mult    (u1_mult),
        .o_done    (u1_done),
        .o_product (w_p1)
    );

    // Sequencer, configuration registers, controller state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_target     <= '0;
            r_base       <= '0;
            r_step       <= psa_pkg::ONE_Q16;
            r_inv_step   <= psa_pkg::ONE_Q16;
            r_inv_integ  <= psa_pkg::ONE_Q16;
            r_deriv_time <= psa_pkg::ONE_Q16;
            r_scale      <= 32'(psa_pkg::ONE_Q16);
            r_integral   <= '0;
            r_prev       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    psa_pkg::CFG_TARGET:     r_target     <= $signed(i_cfg_wdata);
                    psa_pkg::CFG_BASE:       r_base       <= $signed(i_cfg_wdata);
                    psa_pkg::CFG_STEP:       r_step       <= i_cfg_wdata[30:0];
                    psa_pkg::CFG_INV_STEP:   r_inv_step   <= i_cfg_wdata[30:0];
                    psa_pkg::CFG_INV_INTEG:  r_inv_integ  <= i_cfg_wdata[30:0];
                    psa_pkg::CFG_DERIV_TIME: r_deriv_time <= i_cfg_wdata[30:0];
                    psa_pkg::CFG_SCALE:      r_scale      <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // A new result takes the output register, otherwise a taken one leaves it.
            if ((r_state == S_SET) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_START1;
                    end
                end
                S_START1: r_state <= S_MUL1;
                S_MUL1: begin
                    if (w_both_done) begin
                        r_integral <= n_integral;
                        r_state    <= S_START2;
                    end
                end
                S_START2: r_state <= S_MUL2;
                S_MUL2: begin
                    if (w_both_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_prev  <= r_err;
                    r_state <= S_START3;
                end
                S_START3: r_state <= S_MUL3;
                S_MUL3: begin
                    if (u0_done) begin
                        r_state <= S_SET;
                    end
                end
                S_SET: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working registers of the transaction in flight.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_err <= n_err;
        end
        if ((r_state == S_MUL1) && w_both_done) begin
            r_deriv <= n_deriv;
        end
        if ((r_state == S_MUL2) && w_both_done) begin
            r_ti <= $signed(w_p0[78:16]);
            r_td <= $signed(w_p1[62:16]);
        end
        if (r_state == S_SUM) begin
            r_control <= n_control;
        end
        if ((r_state == S_SET) && w_out_free) begin
            r_out_data <= {r_control, n_setting};
        end
    end

endmodule

@@ rtl/psa_digit_mult.sv @@
// Radix-2^DIGIT_W serial-parallel multiplier. The multiplicand is held in
// parallel, the multiplier is shifted out one digit per cycle, and the partial
// product shifts right into the multiplier register. The top digit of the
// multiplier is taken as signed, so the multiplier is a two's complement value.
module psa_digit_mult #(
    parameter int MCAND_W = psa_pkg::MCAND_W,
    parameter int MULT_W  = psa_pkg::MULT_W,
    parameter int DIGIT_W = psa_pkg::DIGIT_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [MCAND_W-1:0]         i_mcand,
    input  logic        [MULT_W-1:0]          i_mult,
    output logic                              o_done,
    output logic signed [MCAND_W+MULT_W-1:0]  o_product
);

    localparam int NDIG  = MULT_W / DIGIT_W;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int HI_W  = MCAND_W + DIGIT_W + 1;

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [MCAND_W-1:0] r_mcand;
    logic signed [HI_W-1:0]   r_hi;
    logic [MULT_W-1:0]        r_lo;

    logic                     w_last;
    logic signed [DIGIT_W:0]  w_digit;
    logic signed [HI_W-1:0]   w_pp;
    logic signed [HI_W-1:0]   w_partial;
    logic signed [HI_W-1:0]   n_hi;
    logic [MULT_W-1:0]        n_lo;

    // One digit step: add the digit multiple, then shift the pair right.
    always_comb begin
        w_last    = (r_cnt == CNT_W'(NDIG - 1));
        w_digit   = $signed({w_last & r_lo[DIGIT_W-1], r_lo[DIGIT_W-1:0]});
        w_pp      = HI_W'(r_mcand) * HI_W'(w_digit);
        w_partial = r_hi + w_pp;
        n_hi      = w_partial >>> DIGIT_W;
        n_lo      = {w_partial[DIGIT_W-1:0], r_lo[MULT_W-1:DIGIT_W]};
    end

    // Sequencing of the digit steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operand and partial product registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mult;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_done    = r_done;
    assign o_product = $signed({r_hi[MCAND_W-1:0], r_lo});

endmodule

@@ rtl/psa_checker.sv @@
`include "assert_macros.svh"

// Port-level checks on the adjuster's stream behavior.
module psa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [2*psa_pkg::FIELD_W-1:0]  m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    `PSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The block works on one transaction at a time.
    `PSA_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Ready only drops because a transaction was taken.
    `PSA_ASSERT_IMP(a_ready_falls_on_accept, i_clk, i_rst_n, $fell(s_axis_tready), $past(s_axis_tvalid))

    // A new result appears only at the end of a busy stretch.
    `PSA_ASSERT_IMP(a_result_after_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

    // Reset leaves the block idle with no result pending.
    `PSA_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, s_axis_tready && !m_axis_tvalid)

endmodule

bind pid_setpoint_adjuster psa_checker u_psa_checker (.*);
